FILE: rtl/lgb_pkg.sv
// ----------------------------------------------------------------------------
// lgb_pkg: shared types and constants for the life automaton board
// Command codes, cell codes, rule counts and the row edit control struct.
// ----------------------------------------------------------------------------
package lgb_pkg;

   typedef enum logic [1:0] {
      CMD_SET     = 2'd0,
      CMD_CLEAR   = 2'd1,
      CMD_ADVANCE = 2'd2
   } lgb_cmd_type;

   typedef logic [1:0] lgb_cell_type;

   localparam lgb_cell_type CELL_BLANK = 2'd0;
   localparam lgb_cell_type CELL_DEAD  = 2'd1;
   localparam lgb_cell_type CELL_ALIVE = 2'd2;

   localparam logic [3:0] BIRTH_COUNT = 4'd3;
   localparam logic [3:0] KEEP_COUNT  = 4'd2;

   // single-cell edit aimed at one row cell
   typedef struct packed {
      logic set;
      logic clear;
   } lgb_edit_type;

endpackage

FILE: rtl/lgb_if.sv
// ----------------------------------------------------------------------------
// lgb_if: request and response channels of the life automaton board
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lgb_req_if #(parameter int CoordWidth = 4);
   logic                  valid;
   logic                  ready;
   logic [1:0]            cmd;
   logic [CoordWidth-1:0] row;
   logic [CoordWidth-1:0] col;

   modport source (output valid, output cmd, output row, output col, input ready);
   modport sink   (input valid, input cmd, input row, input col, output ready);
endinterface

interface lgb_rsp_if #(parameter int IndexWidth = 4, parameter int CellsWidth = 32);
   logic                  valid;
   logic                  ready;
   logic [IndexWidth-1:0] row_index;
   logic [CellsWidth-1:0] row_cells;
   logic                  last_row;

   modport source (output valid, output row_index, output row_cells, output last_row,
                   input ready);
   modport sink   (input valid, input row_index, input row_cells, input last_row,
                   output ready);
endinterface

FILE: rtl/lgb_row_cell.sv
// ----------------------------------------------------------------------------
// lgb_row_cell: one board row in the row chain
// Holds a row of 2-bit cells; takes its neighbor's row on a shift, else
// applies a set or clear to one column when its row is addressed.
// ----------------------------------------------------------------------------
module lgb_row_cell import lgb_pkg::*; #(
   parameter int Side     = 16,
   parameter int ColWidth = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  logic [2*Side-1:0]   shift_data,
   input  lgb_edit_type        edit,
   input  logic [ColWidth-1:0] col,
   output logic [2*Side-1:0]   row_data
);

   logic [2*Side-1:0] row_ff;
   logic [2*Side-1:0] row_in;

   always_comb begin
      row_in = row_ff;
      if (shift_en) begin
         row_in = shift_data;
      end else begin
         for (int c = 0; c < Side; c++) begin
            if (col == ColWidth'(c)) begin
               if (edit.set) begin
                  row_in[2*c +: 2] = CELL_ALIVE;
               end else if (edit.clear && row_ff[2*c +: 2] == CELL_ALIVE) begin
                  row_in[2*c +: 2] = CELL_DEAD;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_data = row_ff;

endmodule

FILE: rtl/lgb_next_row.sv
// ----------------------------------------------------------------------------
// lgb_next_row: B3/S23 rule for one row
// Counts alive neighbors per column from the rows above, current and below;
// columns off the board count as empty.
// ----------------------------------------------------------------------------
module lgb_next_row import lgb_pkg::*; #(
   parameter int Side = 16
) (
   input  logic [2*Side-1:0] above,
   input  logic [2*Side-1:0] cur,
   input  logic [2*Side-1:0] below,
   output logic [2*Side-1:0] next_row
);

   // alive flags padded with an empty column on each side
   logic [Side+1:0] up_alive;
   logic [Side+1:0] mid_alive;
   logic [Side+1:0] dn_alive;

   always_comb begin
      up_alive  = '0;
      mid_alive = '0;
      dn_alive  = '0;
      for (int c = 0; c < Side; c++) begin
         up_alive[c+1]  = (above[2*c +: 2] == CELL_ALIVE);
         mid_alive[c+1] = (cur[2*c +: 2] == CELL_ALIVE);
         dn_alive[c+1]  = (below[2*c +: 2] == CELL_ALIVE);
      end
   end

   always_comb begin
      logic [3:0] n;
      next_row = cur;
      for (int c = 0; c < Side; c++) begin
         n = 4'(up_alive[c]) + 4'(up_alive[c+1]) + 4'(up_alive[c+2])
           + 4'(mid_alive[c]) + 4'(mid_alive[c+2])
           + 4'(dn_alive[c]) + 4'(dn_alive[c+1]) + 4'(dn_alive[c+2]);
         if (mid_alive[c+1]) begin
            if (n != KEEP_COUNT && n != BIRTH_COUNT) begin
               next_row[2*c +: 2] = CELL_DEAD;
            end
         end else if (n == BIRTH_COUNT) begin
            next_row[2*c +: 2] = CELL_ALIVE;
         end
      end
   end

endmodule

FILE: rtl/life_automaton_board.sv
// ----------------------------------------------------------------------------
// life_automaton_board: Conway B3/S23 board on a bounded SIDE x SIDE grid
// Usage:
//   req carries cmd/row/col. Set makes a cell alive, clear turns an alive
//   cell dead; neither returns a response. Coordinates off the
//   board are ignored, as is an unused command code.
//   Advance computes one generation and returns SIDE responses on rsp, rows
//   0 to SIDE-1, last_row high on the final one.
//   The board is a chain of SIDE row registers. During an advance the chain
//   rotates one row per cycle while the output register is free: the head
//   row goes through the rule logic with its neighbors and the new row
//   re-enters at the tail. req.ready is low during the sweep.
//   The response is a single output register. When the receiver holds
//   rsp.ready low the sweep pauses and resumes once the row is taken.
//   Reset (synchronous) makes every cell blank and drops any sweep.
// ----------------------------------------------------------------------------
module life_automaton_board import lgb_pkg::*; #(
   parameter int SIDE = 16
) (
   input  logic       clock,
   input  logic       reset,
   lgb_req_if.sink    req,
   lgb_rsp_if.source  rsp
);

   localparam int IndexWidth = $clog2(SIDE);
   localparam int CellsWidth = 2 * SIDE;
   localparam logic [IndexWidth-1:0] LastStep = IndexWidth'(SIDE - 1);

   logic                  busy_ff, busy_in;
   logic [IndexWidth-1:0] step_ff, step_in;
   logic [CellsWidth-1:0] window_ff, window_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IndexWidth-1:0] rsp_index_ff, rsp_index_in;
   logic [CellsWidth-1:0] rsp_cells_ff, rsp_cells_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  on_board;
   logic                  step_fire;
   logic                  last_step;
   logic [CellsWidth-1:0] below_row;
   logic [CellsWidth-1:0] next_row;
   logic [CellsWidth-1:0] row_data [SIDE];
   lgb_edit_type          edit;

   assign req.ready = !busy_ff;
   assign accept    = req.valid && !busy_ff;
   assign on_board  = ({1'b0, req.row} < (IndexWidth+1)'(SIDE))
                   && ({1'b0, req.col} < (IndexWidth+1)'(SIDE));
   assign edit.set   = accept && on_board && (req.cmd == CMD_SET);
   assign edit.clear = accept && on_board && (req.cmd == CMD_CLEAR);

   // advance one row whenever the output register is free
   assign step_fire = busy_ff && (!rsp_valid_ff || rsp.ready);
   assign last_step = (step_ff == LastStep);
   assign below_row = last_step ? '0 : row_data[1];

   for (genvar k = 0; k < SIDE; k++) begin : g_rows
      logic [CellsWidth-1:0] shift_src;
      if (k == SIDE - 1) begin : g_tail
         assign shift_src = next_row;
      end else begin : g_body
         assign shift_src = row_data[k+1];
      end
      lgb_row_cell #(
         .Side     (SIDE),
         .ColWidth (IndexWidth)
      ) u_row (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (step_fire),
         .shift_data (shift_src),
         .edit       (req.row == IndexWidth'(k) ? edit : '0),
         .col        (req.col),
         .row_data   (row_data[k])
      );
   end

   lgb_next_row #(
      .Side (SIDE)
   ) u_rule (
      .above    (window_ff),
      .cur      (row_data[0]),
      .below    (below_row),
      .next_row (next_row)
   );

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      window_in    = window_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_index_in = rsp_index_ff;
      rsp_cells_in = rsp_cells_ff;
      rsp_last_in  = rsp_last_ff;
      if (accept && req.cmd == CMD_ADVANCE) begin
         busy_in   = 1'b1;
         step_in   = '0;
         window_in = '0;
      end
      if (step_fire) begin
         // keep the unmodified current row as the next row's upper neighbor
         window_in    = row_data[0];
         step_in      = step_ff + 1'b1;
         rsp_valid_in = 1'b1;
         rsp_index_in = step_ff;
         rsp_cells_in = next_row;
         rsp_last_in  = last_step;
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         window_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_cells_ff <= rsp_cells_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.row_index = rsp_index_ff;
   assign rsp.row_cells = rsp_cells_ff;
   assign rsp.last_row  = rsp_last_ff;

`ifndef SYNTHESIS
   a_advance_starts: assert property (@(posedge clock) disable iff (reset)
      accept && req.cmd == CMD_ADVANCE |=> busy_ff && step_ff == '0)
      else $error("advance request did not start a sweep at row zero");

   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      step_fire && last_step |=> !busy_ff && rsp.valid && rsp.last_row)
      else $error("final sweep step did not close the dump");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.last_row |-> rsp.row_index == LastStep)
      else $error("last_row marked on a row other than the final one");

   a_rows_in_order: assert property (@(posedge clock) disable iff (reset)
      step_fire && step_ff != '0 |-> rsp_index_ff == step_ff - 1'b1)
      else $error("response rows out of order");
`endif

endmodule
